[hdl/khr_pkg.sv]
// Shared types, codes and the publish decision for the keyed handle registry.
// Depends on nothing; every other file in the block imports it.
package khr_pkg;

   localparam int KEY_W    = 32;
   localparam int HANDLE_W = 32;

   // Command codes.
   localparam logic [1:0] CMD_PUBLISH = 2'd0;
   localparam logic [1:0] CMD_LOOKUP  = 2'd1;
   localparam logic [1:0] CMD_CLEAR   = 2'd2;

   // Status codes.
   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_ZERO_ARG = 2'd1;
   localparam logic [1:0] ST_FULL     = 2'd2;
   localparam logic [1:0] ST_PRESENT  = 2'd3;

   // One registered command.
   typedef struct packed {
      logic                valid;
      logic [1:0]          command;
      logic [KEY_W-1:0]    key;
      logic [HANDLE_W-1:0] handle;
   } req_type;

   // What the table reports about the registered command's key.
   typedef struct packed {
      logic                hit;
      logic [HANDLE_W-1:0] hit_handle;
      logic                has_free;
   } look_type;

   // Outcome of a publish: argument check first, then duplicate, then space.
   function automatic logic [1:0] publish_status(
      input logic [KEY_W-1:0]    key,
      input logic [HANDLE_W-1:0] handle,
      input logic                present,
      input logic                has_free
   );
      logic [1:0] st;
      if (key == '0 || handle == '0) begin
         st = ST_ZERO_ARG;
      end else if (present) begin
         st = ST_PRESENT;
      end else if (has_free) begin
         st = ST_OK;
      end else begin
         st = ST_FULL;
      end
      return st;
   endfunction

endpackage

[hdl/khr_req_stage.sv]
// Input register of the keyed handle registry: captures each command transfer.
// Depends on khr_pkg for the request struct.
module khr_req_stage (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [1:0]                    req_command,
   input  logic [khr_pkg::KEY_W-1:0]     req_key,
   input  logic [khr_pkg::HANDLE_W-1:0]  req_handle,
   output khr_pkg::req_type              req
);
   import khr_pkg::*;

   logic    valid_ff, valid_in;
   req_type data_ff;

   assign valid_in = start;

   // The valid bit is control state and is cleared by reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Payload is captured on every transfer and needs no reset.
   always_ff @(posedge clock) begin
      if (start) begin
         data_ff.valid   <= 1'b1;
         data_ff.command <= req_command;
         data_ff.key     <= req_key;
         data_ff.handle  <= req_handle;
      end
   end

   always_comb begin
      req.valid   = valid_ff;
      req.command = data_ff.command;
      req.key     = data_ff.key;
      req.handle  = data_ff.handle;
   end

endmodule

[hdl/khr_table.sv]
// Entry storage of the keyed handle registry: parallel key compare, lowest
// free entry select, and the publish and clear updates. Depends on khr_pkg.
module khr_table #(
   parameter int ENTRIES = 4
) (
   input  logic              clock,
   input  logic              reset,
   input  khr_pkg::req_type  req,
   output khr_pkg::look_type look
);
   import khr_pkg::*;

   logic [KEY_W-1:0]    keys_ff    [ENTRIES];
   logic [HANDLE_W-1:0] handles_ff [ENTRIES];

   logic [ENTRIES-1:0]  hit_vec;
   logic [ENTRIES-1:0]  free_vec;
   logic [ENTRIES-1:0]  pick_vec;
   logic [HANDLE_W-1:0] hit_handle;
   logic                do_write;
   logic                do_clear;

   // Compare every entry at once; a zero key never hits a free entry.
   // Keys are unique, so at most one entry hits and an OR picks its handle.
   always_comb begin
      hit_handle = '0;
      for (int i = 0; i < ENTRIES; i++) begin
         hit_vec[i]  = (keys_ff[i] == req.key) && (req.key != '0);
         free_vec[i] = (keys_ff[i] == '0);
         hit_handle  = hit_handle | (handles_ff[i] & {HANDLE_W{hit_vec[i]}});
      end
      // Isolate the lowest numbered free entry.
      pick_vec = free_vec & (~free_vec + ENTRIES'(1));
   end

   always_comb begin
      look.hit        = |hit_vec;
      look.hit_handle = hit_handle;
      look.has_free   = |free_vec;
   end

   assign do_write = req.valid && (req.command == CMD_PUBLISH) &&
                     (publish_status(req.key, req.handle, look.hit, look.has_free) == ST_OK);
   assign do_clear = req.valid && (req.command == CMD_CLEAR);

   // Keys mark occupancy, so reset and clear zero them.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < ENTRIES; i++) begin
            keys_ff[i] <= '0;
         end
      end else begin
         for (int i = 0; i < ENTRIES; i++) begin
            if (do_clear) begin
               keys_ff[i] <= '0;
            end else if (do_write && pick_vec[i]) begin
               keys_ff[i] <= req.key;
            end
         end
      end
   end

   // A handle is only read through a hit on a key written with it.
   always_ff @(posedge clock) begin
      for (int i = 0; i < ENTRIES; i++) begin
         if (do_write && pick_vec[i]) begin
            handles_ff[i] <= req.handle;
         end
      end
   end

   // A key is never stored twice, so no more than one entry may hit.
   a_single_hit: assert property (@(posedge clock) disable iff (reset)
      $onehot0(hit_vec))
      else $error("more than one entry holds the same key");

   // A write always lands in exactly one free entry.
   a_write_target: assert property (@(posedge clock) disable iff (reset)
      do_write |-> $onehot(pick_vec))
      else $error("publish without a single free entry");

   // After a clear every entry is free.
   a_clear_empties: assert property (@(posedge clock) disable iff (reset)
      do_clear |=> (&free_vec))
      else $error("entries still occupied after clear");

endmodule

[hdl/khr_rsp_stage.sv]
// Result register of the keyed handle registry: forms status, found and the
// handle from the table report and drives the result strobe. Depends on khr_pkg.
module khr_rsp_stage (
   input  logic                          clock,
   input  logic                          reset,
   input  khr_pkg::req_type              req,
   input  khr_pkg::look_type             look,
   output logic                          rsp_valid,
   output logic [1:0]                    rsp_status,
   output logic                          rsp_found,
   output logic [khr_pkg::HANDLE_W-1:0]  rsp_found_handle
);
   import khr_pkg::*;

   logic                valid_ff, valid_in;
   logic [1:0]          status_ff, status_in;
   logic                found_ff, found_in;
   logic [HANDLE_W-1:0] handle_ff, handle_in;

   // Only publish reports an error; only lookup reports a hit.
   always_comb begin
      valid_in  = req.valid;
      status_in = ST_OK;
      found_in  = 1'b0;
      handle_in = '0;
      case (req.command)
         CMD_PUBLISH: begin
            status_in = publish_status(req.key, req.handle, look.hit, look.has_free);
         end
         CMD_LOOKUP: begin
            found_in  = look.hit;
            handle_in = look.hit_handle;
         end
         default: begin
            status_in = ST_OK;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      status_ff <= status_in;
      found_ff  <= found_in;
      handle_ff <= handle_in;
   end

   assign rsp_valid        = valid_ff;
   assign rsp_status       = status_ff;
   assign rsp_found        = found_ff;
   assign rsp_found_handle = handle_ff;

endmodule

[hdl/keyed_handle_registry_top.sv]
// Keyed handle registry: a small key to handle table with publish, lookup
// and clear commands. Depends on khr_pkg, khr_req_stage, khr_table, khr_rsp_stage.
//
// Usage:
//  - Command channel: a transfer happens at a rising edge with start high and
//    busy low. busy is always low, so a command may be issued every cycle.
//  - Result channel: each command yields one result, shown for one cycle with
//    rsp_valid high after the command register and the result register. The
//    receiver cannot stall; it must take each result in the cycle it appears.
//  - Throughput is one command per cycle. The entry compare, free entry
//    select and table update all sit between the command register and the
//    result register, so each command sees the table left by the one before.
//  - Publish stores a nonzero key and handle in the lowest free entry, or
//    reports a zero argument, a key already present, or a full table.
//  - Lookup returns found and the stored handle, or zero when there is none.
//  - Clear frees every entry.
//  - Reset (synchronous, active high) frees every entry and drops any
//    command in flight; no result is shown for it.
//  - ENTRIES sets the table depth, from 1 to 64.
module keyed_handle_registry_top #(
   parameter int ENTRIES = 4
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [1:0]                    req_command,
   input  logic [khr_pkg::KEY_W-1:0]     req_key,
   input  logic [khr_pkg::HANDLE_W-1:0]  req_handle,
   output logic                          rsp_valid,
   output logic [1:0]                    rsp_status,
   output logic                          rsp_found,
   output logic [khr_pkg::HANDLE_W-1:0]  rsp_found_handle
);
   import khr_pkg::*;

   req_type  req;
   look_type look;

   // A new command is taken every cycle.
   assign busy = 1'b0;

   khr_req_stage u_req (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .req_command (req_command),
      .req_key     (req_key),
      .req_handle  (req_handle),
      .req         (req)
   );

   khr_table #(
      .ENTRIES (ENTRIES)
   ) u_table (
      .clock (clock),
      .reset (reset),
      .req   (req),
      .look  (look)
   );

   khr_rsp_stage u_rsp (
      .clock            (clock),
      .reset            (reset),
      .req              (req),
      .look             (look),
      .rsp_valid        (rsp_valid),
      .rsp_status       (rsp_status),
      .rsp_found        (rsp_found),
      .rsp_found_handle (rsp_found_handle)
   );

   // Every command transfer yields a result through the command and result registers.
   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##2 rsp_valid)
      else $error("command transfer produced no result");

   // No result appears without a command transfer before it.
   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      !start |-> ##2 !rsp_valid)
      else $error("result without a command transfer");

   // A hit is only reported with good status.
   a_found_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_found) |-> (rsp_status == ST_OK))
      else $error("hit reported with error status");

   // A result without a hit carries a zero handle.
   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_found) |-> (rsp_found_handle == '0))
      else $error("nonzero handle without a hit");

endmodule
